// ----- src/srf_pkg.sv -----
// ----------------------------------------------------------------------------
// srf_pkg
// Types and constants shared by the sample ring FIFO modules.
// ----------------------------------------------------------------------------
package srf_pkg;

	// Defaults for the top level parameters.
	localparam int RING_DEPTH_DEF = 2048;
	localparam int AXES_DEF       = 6;
	localparam int MAX_DRAIN_DEF  = 60;

	// Width of the step counter and of drain counts; holds up to 127.
	localparam int CNT_W = 7;

	typedef enum logic [1:0] {
		CMD_PUSH    = 2'd0,
		CMD_DRAIN   = 2'd1,
		CMD_RESTART = 2'd2
	} cmd_t;

	typedef struct packed {
		cmd_t               cmd;
		logic signed [15:0] axis_0;
		logic signed [15:0] axis_1;
		logic signed [15:0] axis_2;
		logic signed [15:0] axis_3;
		logic signed [15:0] axis_4;
		logic signed [15:0] axis_5;
		logic        [5:0]  max_values;
	} req_t;

	typedef struct packed {
		logic signed [15:0] value;
		logic               last;
		logic               empty_res;
		logic        [5:0]  value_count;
	} res_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic item_load;
		logic ptr_clear;
		logic step_clear;
		logic step_inc;
		logic ram_write;
		logic ram_read;
		logic wp_advance;
		logic rp_advance;
		logic res_load_value;
		logic res_load_empty;
	} ctl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic push_room;
		logic drain_zero;
		logic push_last;
		logic drain_last;
		logic res_free;
	} ctl_sts_t;

endpackage

// ----- src/srf_ram.sv -----
// ----------------------------------------------------------------------------
// srf_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module srf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[addr];
		end
	end

endmodule

// ----- src/srf_ctrl.sv -----
// ----------------------------------------------------------------------------
// srf_ctrl
// Sequencer for push, drain and restart requests of the sample ring FIFO.
// ----------------------------------------------------------------------------
module srf_ctrl
	import srf_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	input  cmd_t     req_cmd,
	output logic     req_stall,
	output ctl_cmd_t ctl,
	input  ctl_sts_t sts
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PUSH,
		ST_DRAIN_RD,
		ST_DRAIN_LD,
		ST_EMPTY
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   accept;

	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && (state_q == ST_IDLE);

	always_comb begin
		ctl       = '0;
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					ctl.item_load  = 1'b1;
					ctl.step_clear = 1'b1;
					unique case (req_cmd)
						CMD_PUSH: begin
							if (sts.push_room) begin
								state_nxt = ST_PUSH;
							end
						end
						CMD_DRAIN: begin
							state_nxt = sts.drain_zero ? ST_EMPTY : ST_DRAIN_RD;
						end
						CMD_RESTART: begin
							ctl.ptr_clear = 1'b1;
						end
						default: begin
						end
					endcase
				end
			end
			ST_PUSH: begin
				ctl.ram_write = 1'b1;
				if (sts.push_last) begin
					ctl.wp_advance = 1'b1;
					state_nxt      = ST_IDLE;
				end else begin
					ctl.step_inc = 1'b1;
				end
			end
			ST_DRAIN_RD: begin
				ctl.ram_read = 1'b1;
				state_nxt    = ST_DRAIN_LD;
			end
			ST_DRAIN_LD: begin
				if (sts.res_free) begin
					ctl.res_load_value = 1'b1;
					if (sts.drain_last) begin
						ctl.rp_advance = 1'b1;
						state_nxt      = ST_IDLE;
					end else begin
						ctl.step_inc = 1'b1;
						state_nxt    = ST_DRAIN_RD;
					end
				end
			end
			ST_EMPTY: begin
				if (sts.res_free) begin
					ctl.res_load_empty = 1'b1;
					state_nxt          = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

// ----- src/srf_dpath.sv -----
// ----------------------------------------------------------------------------
// srf_dpath
// Pointers, ring memory, drain count and result register of the ring FIFO.
// ----------------------------------------------------------------------------
module srf_dpath
	import srf_pkg::*;
#(
	parameter int RING_DEPTH = RING_DEPTH_DEF,
	parameter int AXES       = AXES_DEF,
	parameter int MAX_DRAIN  = MAX_DRAIN_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  req_t     req,
	output res_t     res,
	output logic     res_valid,
	input  logic     res_stall,
	input  ctl_cmd_t ctl,
	output ctl_sts_t sts
);

	localparam int AW    = $clog2(RING_DEPTH);
	localparam int PW    = AW + 1;
	localparam int NSAMP = MAX_DRAIN / AXES;

	req_t             item_q;
	logic [PW-1:0]    wp_q;
	logic [PW-1:0]    rp_q;
	logic [CNT_W-1:0] step_q;
	logic [CNT_W-1:0] n_q;
	logic [PW-1:0]    fill;
	logic [CNT_W-1:0] req_cap;
	logic [CNT_W-1:0] avail;
	logic [CNT_W-1:0] n_round;
	logic [AW-1:0]    ram_addr;
	logic [15:0]      ram_wdata;
	logic [15:0]      ram_rdata;
	logic             res_valid_q;
	res_t             res_q;

	assign fill = wp_q - rp_q;

	// Drain count: cap the request, limit it to the fill level, then round
	// it down to whole samples.
	always_comb begin
		req_cap = ({1'b0, req.max_values} > CNT_W'(MAX_DRAIN)) ?
			CNT_W'(MAX_DRAIN) : {1'b0, req.max_values};
		avail   = (fill < PW'(req_cap)) ? fill[CNT_W-1:0] : req_cap;
		n_round = '0;
		for (int k = 0; k <= NSAMP; k++) begin
			if (CNT_W'(k * AXES) <= avail) begin
				n_round = CNT_W'(k * AXES);
			end
		end
	end

	assign sts.push_room  = (fill <= PW'(RING_DEPTH - AXES));
	assign sts.drain_zero = (n_round == '0);
	assign sts.push_last  = (step_q == CNT_W'(AXES - 1));
	assign sts.drain_last = ((step_q + 1'b1) == n_q);
	assign sts.res_free   = !res_valid_q || !res_stall;

	always_comb begin
		unique case (step_q)
			CNT_W'(0): ram_wdata = item_q.axis_0;
			CNT_W'(1): ram_wdata = item_q.axis_1;
			CNT_W'(2): ram_wdata = item_q.axis_2;
			CNT_W'(3): ram_wdata = item_q.axis_3;
			CNT_W'(4): ram_wdata = item_q.axis_4;
			CNT_W'(5): ram_wdata = item_q.axis_5;
			default:   ram_wdata = '0;
		endcase
	end

	assign ram_addr = ctl.ram_write ? AW'(wp_q + PW'(step_q)) : AW'(rp_q + PW'(step_q));

	srf_ram #(
		.WIDTH(16),
		.DEPTH(RING_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ctl.ram_write),
		.re   (ctl.ram_read),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q        <= '0;
			rp_q        <= '0;
			step_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (ctl.ptr_clear) begin
				wp_q <= '0;
				rp_q <= '0;
			end
			if (ctl.wp_advance) begin
				wp_q <= wp_q + PW'(AXES);
			end
			if (ctl.rp_advance) begin
				rp_q <= rp_q + PW'(n_q);
			end
			if (ctl.step_clear) begin
				step_q <= '0;
			end else if (ctl.step_inc) begin
				step_q <= step_q + 1'b1;
			end
			if (ctl.res_load_value || ctl.res_load_empty) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.item_load) begin
			item_q <= req;
			n_q    <= n_round;
		end
		if (ctl.res_load_value) begin
			res_q.value       <= ram_rdata;
			res_q.last        <= sts.drain_last;
			res_q.empty_res   <= 1'b0;
			res_q.value_count <= 6'(n_q);
		end else if (ctl.res_load_empty) begin
			res_q.value       <= '0;
			res_q.last        <= 1'b1;
			res_q.empty_res   <= 1'b1;
			res_q.value_count <= '0;
		end
	end

	assign res       = res_q;
	assign res_valid = res_valid_q;

endmodule

// ----- src/sample_ring_fifo.sv -----
// ----------------------------------------------------------------------------
// sample_ring_fifo: ring FIFO of signed 16-bit values kept as whole samples.
// A stored push writes its AXES values in turn; a dropped push, a restart or
// the unused code ends on acceptance. A drain reads out its values in turn,
// held by result stalls. Reset clears pointers, step count, controller and valid.
// ----------------------------------------------------------------------------
module sample_ring_fifo
	import srf_pkg::*;
#(
	parameter int RING_DEPTH = RING_DEPTH_DEF,
	parameter int AXES       = AXES_DEF,
	parameter int MAX_DRAIN  = MAX_DRAIN_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic res_valid,
	input  logic res_stall,
	output res_t res
);

	// The controller sequences each request; only one request is in work at
	// a time, and the request channel stalls until its sequence completes.
	ctl_cmd_t ctl;
	ctl_sts_t sts;

	srf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_cmd  (req.cmd),
		.req_stall(req_stall),
		.ctl      (ctl),
		.sts      (sts)
	);

	// The datapath holds the pointers, the ring memory and the result
	// register, which decouples the result side from the sequencer.
	srf_dpath #(
		.RING_DEPTH(RING_DEPTH),
		.AXES      (AXES),
		.MAX_DRAIN (MAX_DRAIN)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.res      (res),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.ctl      (ctl),
		.sts      (sts)
	);

`ifndef SYNTH
	// An empty drain result is always final and reports no values.
	a_empty_form: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.empty_res |-> res.last && (res.value_count == 6'd0))
		else $error("empty result malformed");

	// A value result always reports a nonzero count.
	a_value_count: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.empty_res |-> (res.value_count != 6'd0))
		else $error("value result with zero count");

	// An accepted drain always occupies the sequencer in the next cycle.
	a_drain_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && (req.cmd == CMD_DRAIN) |=> req_stall)
		else $error("drain did not stall the request channel");
`endif

endmodule

// ----- tb/sample_ring_fifo_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sample_ring_fifo_tb
// Self-checking bench for the sample ring FIFO. A queue of requests feeds a
// clocked driver, and a clocked monitor checks every drained value against a
// shadow copy of the ring that is updated as each request is accepted.
// ----------------------------------------------------------------------------
module sample_ring_fifo_tb
	import srf_pkg::*;
();

	// Pointers count modulo twice the ring depth, so they carry one extra bit.
	localparam int PTR_W = $clog2(RING_DEPTH_DEF) + 1;

	// The command field has one code that the block must ignore.
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	// The tail wait at the end is sized to cover the longest drain, with some margin.
	localparam int DRAIN_TAIL = 2 * MAX_DRAIN_DEF + AXES_DEF + 16;

	// The limit is far above what a correct run needs, even with
	// heavy stalling on the result side.
	localparam int CYCLE_LIMIT = 1500000;

	localparam int RANDOM_PER_PHASE = 60;

	// A burst of pushes that the capped drains of the last phase run dry.
	localparam int BURST_PUSHES = 40;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	res_t res;

	sample_ring_fifo dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	always #4 clk = ~clk;

	// Shadow copy of the ring. Entries are only ever read between the
	// pointers, so the initial contents never matter.
	logic [15:0]      shadow_mem [RING_DEPTH_DEF];
	logic [PTR_W-1:0] shadow_wp = '0;
	logic [PTR_W-1:0] shadow_rp = '0;

	// Values that drains have produced in the shadow ring and that the block
	// still owes us, oldest first.
	res_t drained_due [$];

	// Requests waiting for the driver.
	req_t pending [$];

	int queued_cnt   = 0;
	int accepted_cnt = 0;
	int checked_cnt  = 0;
	int fail_count   = 0;
	int report_count = 0;
	int cycle_cnt    = 0;

	// Tallies for the closing summary.
	int stored_cnt  = 0;
	int dropped_cnt = 0;
	int drain_cnt   = 0;
	int empty_cnt   = 0;
	int restart_cnt = 0;
	int unused_cnt  = 0;

	// Percent of free cycles in which each side holds back.
	int send_idle_pct = 29;
	int recv_idle_pct = 88;

	// Apply one accepted request to the shadow ring and queue the values that
	// a drain must produce.
	task automatic shadow_ring_step(input req_t r);
		logic [PTR_W-1:0] level;
		logic [PTR_W-1:0] slot;
		logic [15:0]      axes [AXES_DEF];
		int               want;
		int               n;
		res_t             item;
		level = shadow_wp - shadow_rp;
		case (r.cmd)
			CMD_PUSH: begin
				// A sample is kept whole: with too little room it is dropped.
				if (int'(level) > RING_DEPTH_DEF - AXES_DEF) begin
					dropped_cnt++;
				end else begin
					axes = '{r.axis_0, r.axis_1, r.axis_2, r.axis_3, r.axis_4, r.axis_5};
					for (int k = 0; k < AXES_DEF; k++) begin
						slot = shadow_wp + PTR_W'(k);
						shadow_mem[slot[PTR_W-2:0]] = axes[k];
					end
					shadow_wp = shadow_wp + PTR_W'(AXES_DEF);
					stored_cnt++;
				end
			end
			CMD_DRAIN: begin
				drain_cnt++;
				// Oversized requests saturate, and the count is rounded down to
				// whole samples.
				want = (r.max_values > MAX_DRAIN_DEF) ? MAX_DRAIN_DEF : int'(r.max_values);
				n = (int'(level) < want) ? int'(level) : want;
				n -= n % AXES_DEF;
				if (n == 0) begin
					// Nothing to hand out: a single flagged result, pointers stay.
					item.value       = '0;
					item.last        = 1'b1;
					item.empty_res   = 1'b1;
					item.value_count = '0;
					drained_due.push_back(item);
					empty_cnt++;
				end else begin
					for (int i = 0; i < n; i++) begin
						slot = shadow_rp + PTR_W'(i);
						item.value       = shadow_mem[slot[PTR_W-2:0]];
						item.last        = (i == n - 1);
						item.empty_res   = 1'b0;
						item.value_count = 6'(n);
						drained_due.push_back(item);
					end
					shadow_rp = shadow_rp + PTR_W'(n);
				end
			end
			CMD_RESTART: begin
				shadow_wp = '0;
				shadow_rp = '0;
				restart_cnt++;
			end
			default: begin
				// The unused code changes nothing.
				unused_cnt++;
			end
		endcase
	endtask

	// Axis values lean toward the extremes and the values around zero.
	function automatic logic [15:0] pick_axis();
		case ($urandom_range(0, 7))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'h0000;
			3: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic queue_item(input req_t r);
		pending.push_back(r);
		queued_cnt++;
	endtask

	task automatic queue_push(input logic [15:0] a0, a1, a2, a3, a4, a5);
		req_t r;
		r.cmd        = CMD_PUSH;
		r.axis_0     = a0;
		r.axis_1     = a1;
		r.axis_2     = a2;
		r.axis_3     = a3;
		r.axis_4     = a4;
		r.axis_5     = a5;
		r.max_values = 6'($urandom_range(0, 63));
		queue_item(r);
	endtask

	// Drains carry random axis fields, which the block must ignore.
	task automatic queue_drain(input logic [5:0] limit);
		req_t r;
		r.cmd        = CMD_DRAIN;
		r.axis_0     = pick_axis();
		r.axis_1     = pick_axis();
		r.axis_2     = pick_axis();
		r.axis_3     = pick_axis();
		r.axis_4     = pick_axis();
		r.axis_5     = pick_axis();
		r.max_values = limit;
		queue_item(r);
	endtask

	task automatic queue_other(input logic [1:0] code);
		req_t r;
		r            = '0;
		r.cmd        = cmd_t'(code);
		r.axis_0     = pick_axis();
		r.axis_3     = pick_axis();
		r.max_values = 6'($urandom_range(0, 63));
		queue_item(r);
	endtask

	// Random requests are mostly pushes and drains, with a few restarts and
	// unused codes. Drains often ask for a small count so that rounding down
	// to whole samples is exercised. Unused codes do not count toward the total.
	task automatic queue_random(input int count);
		req_t r;
		int   made;
		int   roll;
		made = 0;
		while (made < count) begin
			r.axis_0     = pick_axis();
			r.axis_1     = pick_axis();
			r.axis_2     = pick_axis();
			r.axis_3     = pick_axis();
			r.axis_4     = pick_axis();
			r.axis_5     = pick_axis();
			r.max_values = ($urandom_range(0, 1) != 0) ? 6'($urandom_range(0, 13))
			                                          : 6'($urandom_range(0, 63));
			roll = $urandom_range(0, 99);
			if (roll < 52) begin
				r.cmd = CMD_PUSH;
			end else if (roll < 90) begin
				r.cmd = CMD_DRAIN;
			end else if (roll < 96) begin
				r.cmd = CMD_RESTART;
			end else begin
				r.cmd = cmd_t'(CMD_UNUSED);
			end
			queue_item(r);
			if (r.cmd != cmd_t'(CMD_UNUSED)) begin
				made++;
			end
		end
	endtask

	// Block until every queued request has been accepted and every value
	// owed by the block has come out.
	task automatic wait_settled();
		while (accepted_cnt != queued_cnt) begin
			@(posedge clk);
		end
		while (drained_due.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// Driver. A request is accepted at an edge where valid is high and stall
	// is low; the shadow ring is updated right then. A new request is only
	// presented once the current one is gone, so a stalled request holds.
	// Valid is assigned once per edge at most.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req       <= '0;
		end else begin
			if (req_valid && !req_stall) begin
				shadow_ring_step(req);
				accepted_cnt++;
			end
			if (!req_valid || !req_stall) begin
				if (pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					req       <= pending.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor. Each accepted result is compared field by field with the oldest
	// value still owed. The stall is rolled fresh every cycle.
	always @(posedge clk or negedge arst_n) begin : result_watch
		res_t oldest;
		if (!arst_n) begin
			res_stall <= 1'b0;
		end else begin
			if (res_valid && !res_stall) begin
				checked_cnt++;
				if (drained_due.size() == 0) begin
					fail_count++;
					if (report_count < 10) begin
						report_count++;
						$display("unexpected result: value %0d last %0b empty %0b count %0d",
							res.value, res.last, res.empty_res, res.value_count);
					end
				end else begin
					oldest = drained_due.pop_front();
					if (res.value !== oldest.value || res.last !== oldest.last ||
						res.empty_res !== oldest.empty_res ||
						res.value_count !== oldest.value_count) begin
						fail_count++;
						if (report_count < 10) begin
							report_count++;
							$display("mismatch: exp value %0d last %0b empty %0b count %0d",
								oldest.value, oldest.last, oldest.empty_res,
								oldest.value_count);
							$display("          act value %0d last %0b empty %0b count %0d",
								res.value, res.last, res.empty_res, res.value_count);
						end
					end
				end
			end
			res_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("run stopped after %0d cycles without finishing", cycle_cnt);
			$display("sample_ring_fifo_tb: FAIL");
			$finish;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed requests. A drain on the empty ring gives the flagged result,
		// and the unused code must leave everything alone.
		queue_drain(6'd60);
		queue_other(CMD_UNUSED);
		// Extreme and alternating axis values.
		queue_push(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
		queue_push(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
		queue_push(16'h0000, 16'hFFFF, 16'h0001, 16'h5555, 16'hAAAA, 16'h8001);
		// Requests below one sample round to nothing; one sample exactly; a
		// request above the cap saturates and then is limited by what is stored.
		queue_drain(6'd5);
		queue_drain(6'd6);
		queue_drain(6'd63);
		queue_drain(6'd0);
		// Restart discards what was stored.
		queue_push(16'h1234, 16'hEDCB, 16'h0F0F, 16'hF0F0, 16'h00FF, 16'hFF00);
		queue_push(16'h7FFE, 16'h8002, 16'h0002, 16'hFFFE, 16'h4000, 16'hC000);
		queue_other(CMD_RESTART);
		queue_drain(6'd60);
		// Eleven samples: a capped drain of ten, then the one left over.
		for (int k = 0; k < 11; k++) begin
			queue_push(pick_axis(), pick_axis(), pick_axis(), pick_axis(), pick_axis(),
				pick_axis());
		end
		queue_drain(6'd63);
		queue_drain(6'd60);
		queue_random(RANDOM_PER_PHASE);
		wait_settled();

		// Second phase: the sender is the slow side.
		send_idle_pct = 88;
		recv_idle_pct = 29;
		queue_random(RANDOM_PER_PHASE);
		wait_settled();

		// Last phase runs flat out. After a restart, a burst of pushes is taken
		// out again by capped drains until they come back empty, and more
		// random traffic follows.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		queue_other(CMD_RESTART);
		for (int k = 0; k < BURST_PUSHES; k++) begin
			queue_push(pick_axis(), pick_axis(), pick_axis(), pick_axis(), pick_axis(),
				pick_axis());
		end
		for (int k = 0; k < 12; k++) begin
			queue_drain(6'd63);
		end
		queue_random(RANDOM_PER_PHASE);
		wait_settled();

		// Give a late or extra result time to show up.
		repeat (DRAIN_TAIL) @(posedge clk);
		if (drained_due.size() != 0) begin
			$display("%0d expected values never arrived", drained_due.size());
			fail_count += drained_due.size();
		end

		$display("requests: %0d accepted, %0d samples stored, %0d dropped, %0d restarts",
			accepted_cnt, stored_cnt, dropped_cnt, restart_cnt);
		$display("%0d unused codes; drains: %0d, %0d empty; %0d results checked, %0d failures",
			unused_cnt, drain_cnt, empty_cnt, checked_cnt, fail_count);
		if (fail_count == 0) begin
			$display("sample_ring_fifo_tb: PASS");
		end else begin
			$display("sample_ring_fifo_tb: FAIL");
		end
		$finish;
	end

endmodule
